/* rtl/hrlf_pkg.sv */
// ----------------------------------------------------------------------------
// hrlf_pkg - shared types and constants for the request-line fingerprint
// Byte codes, slot numbering, fingerprint record and the saturating helpers.
// ----------------------------------------------------------------------------
package hrlf_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int NUM_CNT     = 11;
    localparam int VALUE_W     = 16;
    localparam int SLOT_W      = 4;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [VALUE_W-1:0]     value_t;
    typedef logic [SLOT_W-1:0]      slot_t;

    // slot numbering
    localparam slot_t SLOT_CMD       = 4'd0;
    localparam slot_t SLOT_PROTO     = 4'd1;
    localparam slot_t SLOT_LEN       = 4'd2;
    localparam slot_t FIRST_CNT_SLOT = 4'd3;
    localparam slot_t LAST_SLOT      = 4'd13;

    // counter positions, slot minus three
    localparam int CNT_VAR    = 0;
    localparam int CNT_PCT    = 1;
    localparam int CNT_APOS   = 2;
    localparam int CNT_PLUS   = 3;
    localparam int CNT_DDOT   = 4;
    localparam int CNT_BSL    = 5;
    localparam int CNT_OPAR   = 6;
    localparam int CNT_CPAR   = 7;
    localparam int CNT_DSLASH = 8;
    localparam int CNT_LT     = 9;
    localparam int CNT_GT     = 10;

    // command and protocol codes
    localparam logic [3:0] CMD_GET     = 4'd1;
    localparam logic [3:0] CMD_POST    = 4'd2;
    localparam logic [3:0] CMD_HEAD    = 4'd4;
    localparam logic [3:0] CMD_OTHER   = 4'd8;
    localparam logic [3:0] PROTO_X9    = 4'd1;
    localparam logic [3:0] PROTO_X0    = 4'd2;
    localparam logic [3:0] PROTO_X1    = 4'd4;
    localparam logic [3:0] PROTO_OTHER = 4'd8;

    // byte values
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_PCT    = 8'd37;
    localparam logic [7:0] CH_AMP    = 8'd38;
    localparam logic [7:0] CH_APOS   = 8'd39;
    localparam logic [7:0] CH_OPAR   = 8'd40;
    localparam logic [7:0] CH_CPAR   = 8'd41;
    localparam logic [7:0] CH_PLUS   = 8'd43;
    localparam logic [7:0] CH_DOT    = 8'd46;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_ONE    = 8'd49;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_LT     = 8'd60;
    localparam logic [7:0] CH_GT     = 8'd62;
    localparam logic [7:0] CH_QUEST  = 8'd63;
    localparam logic [7:0] CH_A      = 8'd65;
    localparam logic [7:0] CH_D      = 8'd68;
    localparam logic [7:0] CH_E      = 8'd69;
    localparam logic [7:0] CH_G      = 8'd71;
    localparam logic [7:0] CH_H      = 8'd72;
    localparam logic [7:0] CH_O      = 8'd79;
    localparam logic [7:0] CH_P      = 8'd80;
    localparam logic [7:0] CH_S      = 8'd83;
    localparam logic [7:0] CH_T      = 8'd84;
    localparam logic [7:0] CH_BSL    = 8'd92;

    // one finished fingerprint, values already clipped to the slot width
    typedef struct packed {
        logic [3:0]                command;
        logic [3:0]                protocol;
        value_t                    total;
        logic [NUM_CNT-1:0][VALUE_W-1:0] counts;
    } print_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

    function automatic value_t clip_value(input count_t v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'h0000_FFFF) begin
            return 16'hFFFF;
        end
        return w[VALUE_W-1:0];
    endfunction

endpackage

/* rtl/http_request_line_fingerprint.sv */
// ----------------------------------------------------------------------------
// http_request_line_fingerprint - request-line fingerprint of an HTTP header
// Screens the first line of a header byte by byte and reports fourteen
// fingerprint slots when the last byte of the header arrives.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                          | tlast
//  --------+-----------+--------------------------------+--------------------
//  s_      | in        | [7:0] data_byte                | end_of_header
//  m_      | out       | [3:0] slot_index, [19:4] value | final_slot (slot 13)
//
//  Cycles: one header byte is taken every cycle while the queue has room;
//  the fingerprint leaves as fourteen transactions, one per cycle while
//  m_tready is high. Throughput therefore reaches a byte per cycle for headers
//  of fourteen bytes or more; shorter headers are limited by the serialiser.
//  Stalls: a two-entry fingerprint queue parts the classifier from the
//  serialiser, so s_tready falls only when two finished fingerprints wait.
//  Reset: synchronous on aresetn, clearing the control state and counters.
//
module http_request_line_fingerprint (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_header
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] slot_index, [19:4] slot_value, [23:20] zero
    output logic        m_tlast    // final_slot
);

    // front to queue
    logic                 push;
    hrlf_pkg::print_t     push_data;
    // queue to back
    logic                 pop;
    hrlf_pkg::print_t     pop_data;
    hrlf_pkg::q_status_t  q_status;

    // classify each byte and accumulate the fingerprint
    hrlf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // hold finished fingerprints until the serialiser is free
    hrlf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    // advance through the fourteen slots, one transaction per cycle while m_tready is high
    hrlf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .pop_data  (pop_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* rtl/hrlf_front.sv */
// ----------------------------------------------------------------------------
// hrlf_front - byte classifier and fingerprint accumulator
// Examines one header byte per cycle while the queue is not full and pushes a
// finished fingerprint on the last byte of the header.
// ----------------------------------------------------------------------------
module hrlf_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,
    input  hrlf_pkg::q_status_t  q_status,
    output logic                 push,
    output hrlf_pkg::print_t     push_data
);

    logic [3:0]          command_reg, command_next;
    logic                cmd_found_reg, cmd_found_next;
    logic [3:0]          proto_reg, proto_next;
    logic                proto_found_reg, proto_found_next;
    logic [23:0]         recent_reg, recent_next;
    logic [1:0]          pend_reg, pend_next;
    logic                query_reg, query_next;
    logic                line_end_reg, line_end_next;
    hrlf_pkg::count_t    total_reg, total_next;
    hrlf_pkg::count_t    cnt_reg  [hrlf_pkg::NUM_CNT];
    hrlf_pkg::count_t    cnt_next [hrlf_pkg::NUM_CNT];
    logic [hrlf_pkg::NUM_CNT-1:0] inc;
    logic                accept;
    logic [7:0]          b, p1, p2, p3;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && s_tlast;
    assign b        = s_tdata;
    assign p1       = recent_reg[7:0];
    assign p2       = recent_reg[15:8];
    assign p3       = recent_reg[23:16];

    always_comb begin
        command_next     = command_reg;
        cmd_found_next   = cmd_found_reg;
        proto_next       = proto_reg;
        proto_found_next = proto_found_reg;
        recent_next      = recent_reg;
        pend_next        = pend_reg;
        query_next       = query_reg;
        line_end_next    = line_end_reg;
        inc              = '0;
        total_next       = hrlf_pkg::sat_inc(total_reg);

        if (!line_end_reg) begin
            if (b == hrlf_pkg::CH_LF) begin
                line_end_next = 1'b1;
            end else begin
                // protocol version: digit, dot, digit
                if (!proto_found_reg && (p2 inside {hrlf_pkg::CH_ZERO, hrlf_pkg::CH_ONE})
                        && p1 == hrlf_pkg::CH_DOT) begin
                    if (b == hrlf_pkg::CH_ZERO) begin
                        proto_next = hrlf_pkg::PROTO_X0;
                        proto_found_next = 1'b1;
                    end else if (b == hrlf_pkg::CH_NINE) begin
                        proto_next = hrlf_pkg::PROTO_X9;
                        proto_found_next = 1'b1;
                    end else if (b == hrlf_pkg::CH_ONE) begin
                        proto_next = hrlf_pkg::PROTO_X1;
                        proto_found_next = 1'b1;
                    end
                end
                // command word, first match wins
                if (!cmd_found_reg) begin
                    if (p2 == hrlf_pkg::CH_G && p1 == hrlf_pkg::CH_E && b == hrlf_pkg::CH_T) begin
                        command_next = hrlf_pkg::CMD_GET;
                        cmd_found_next = 1'b1;
                    end else if (p3 == hrlf_pkg::CH_H && p2 == hrlf_pkg::CH_E
                            && p1 == hrlf_pkg::CH_A && b == hrlf_pkg::CH_D) begin
                        command_next = hrlf_pkg::CMD_HEAD;
                        cmd_found_next = 1'b1;
                    end else if (p3 == hrlf_pkg::CH_P && p2 == hrlf_pkg::CH_O
                            && p1 == hrlf_pkg::CH_S && b == hrlf_pkg::CH_T) begin
                        command_next = hrlf_pkg::CMD_POST;
                        cmd_found_next = 1'b1;
                    end
                end
                // non-overlapping pairs: a counted pair clears its pending bit
                if (b == hrlf_pkg::CH_DOT) begin
                    inc[hrlf_pkg::CNT_DDOT] = pend_reg[0];
                    pend_next[0] = !pend_reg[0];
                end else begin
                    pend_next[0] = 1'b0;
                end
                if (b == hrlf_pkg::CH_SLASH) begin
                    inc[hrlf_pkg::CNT_DSLASH] = pend_reg[1];
                    pend_next[1] = !pend_reg[1];
                end else begin
                    pend_next[1] = 1'b0;
                end
                case (b)
                    hrlf_pkg::CH_QUEST: query_next = 1'b1;
                    hrlf_pkg::CH_PCT:   inc[hrlf_pkg::CNT_PCT] = 1'b1;
                    hrlf_pkg::CH_AMP:   inc[hrlf_pkg::CNT_VAR] = query_reg;
                    hrlf_pkg::CH_APOS:  inc[hrlf_pkg::CNT_APOS] = 1'b1;
                    hrlf_pkg::CH_PLUS:  inc[hrlf_pkg::CNT_PLUS] = 1'b1;
                    hrlf_pkg::CH_OPAR:  inc[hrlf_pkg::CNT_OPAR] = 1'b1;
                    hrlf_pkg::CH_CPAR:  inc[hrlf_pkg::CNT_CPAR] = 1'b1;
                    hrlf_pkg::CH_LT:    inc[hrlf_pkg::CNT_LT] = 1'b1;
                    hrlf_pkg::CH_GT:    inc[hrlf_pkg::CNT_GT] = 1'b1;
                    hrlf_pkg::CH_BSL:   inc[hrlf_pkg::CNT_BSL] = 1'b1;
                    default: ;
                endcase
                recent_next = {recent_reg[15:0], b};
            end
        end

        for (int k = 0; k < hrlf_pkg::NUM_CNT; k++) begin
            cnt_next[k] = inc[k] ? hrlf_pkg::sat_inc(cnt_reg[k]) : cnt_reg[k];
        end
    end

    // fingerprint includes the last byte itself
    always_comb begin
        push_data.command  = command_next;
        push_data.protocol = proto_next;
        push_data.total    = hrlf_pkg::clip_value(total_next);
        for (int k = 0; k < hrlf_pkg::NUM_CNT; k++) begin
            push_data.counts[k] = hrlf_pkg::clip_value(cnt_next[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            command_reg     <= hrlf_pkg::CMD_OTHER;
            cmd_found_reg   <= 1'b0;
            proto_reg       <= hrlf_pkg::PROTO_OTHER;
            proto_found_reg <= 1'b0;
            recent_reg      <= '0;
            pend_reg        <= '0;
            query_reg       <= 1'b0;
            line_end_reg    <= 1'b0;
            total_reg       <= '0;
            for (int k = 0; k < hrlf_pkg::NUM_CNT; k++) begin
                cnt_reg[k] <= '0;
            end
        end else if (accept) begin
            command_reg     <= command_next;
            cmd_found_reg   <= cmd_found_next;
            proto_reg       <= proto_next;
            proto_found_reg <= proto_found_next;
            recent_reg      <= recent_next;
            pend_reg        <= pend_next;
            query_reg       <= query_next;
            line_end_reg    <= line_end_next;
            total_reg       <= total_next;
            for (int k = 0; k < hrlf_pkg::NUM_CNT; k++) begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

endmodule

/* rtl/hrlf_queue.sv */
// ----------------------------------------------------------------------------
// hrlf_queue - short queue of finished fingerprints
// Decouples the byte classifier from the slot serialiser.
// ----------------------------------------------------------------------------
module hrlf_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  hrlf_pkg::print_t     push_data,
    input  logic                 pop,
    output hrlf_pkg::print_t     pop_data,
    output hrlf_pkg::q_status_t  q_status
);

    hrlf_pkg::print_t                 store [hrlf_pkg::QDEPTH];
    logic [hrlf_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [hrlf_pkg::QPTR_W:0]        fill_reg, fill_next;

    assign q_status.full  = (fill_reg == (hrlf_pkg::QPTR_W+1)'(hrlf_pkg::QDEPTH));
    assign q_status.empty = (fill_reg == '0);
    assign pop_data       = store[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

/* rtl/hrlf_back.sv */
// ----------------------------------------------------------------------------
// hrlf_back - slot serialiser
// Takes one fingerprint from the queue and sends its fourteen slots through
// a registered output stage.
// ----------------------------------------------------------------------------
module hrlf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hrlf_pkg::q_status_t  q_status,
    input  hrlf_pkg::print_t     pop_data,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [3:0] slot_index, [19:4] slot_value
    output logic                 m_tlast
);

    logic                   busy_reg, busy_next;
    hrlf_pkg::slot_t        slot_reg, slot_next;
    hrlf_pkg::print_t       frame_reg;
    logic                   m_tvalid_reg;
    logic [23:0]            m_tdata_reg;
    logic                   m_tlast_reg;
    logic                   out_free, load, done;
    logic [3:0]             cnt_idx;
    hrlf_pkg::value_t       slot_value;

    assign out_free = !m_tvalid_reg || m_tready;
    assign load     = busy_reg && out_free;
    assign done     = load && (slot_reg == hrlf_pkg::LAST_SLOT);
    assign pop      = !q_status.empty && (!busy_reg || done);
    assign cnt_idx  = 4'(slot_reg - hrlf_pkg::FIRST_CNT_SLOT);

    always_comb begin
        case (slot_reg)
            hrlf_pkg::SLOT_CMD:   slot_value = 16'(frame_reg.command);
            hrlf_pkg::SLOT_PROTO: slot_value = 16'(frame_reg.protocol);
            hrlf_pkg::SLOT_LEN:   slot_value = frame_reg.total;
            default:              slot_value = frame_reg.counts[cnt_idx];
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        if (pop) begin
            busy_next = 1'b1;
            slot_next = '0;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (load) begin
            slot_next = slot_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            frame_reg <= pop_data;
        end
        if (load) begin
            m_tdata_reg <= {4'b0, slot_value, slot_reg};
            m_tlast_reg <= (slot_reg == hrlf_pkg::LAST_SLOT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            slot_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* rtl/hrlf_checker.sv */
// ----------------------------------------------------------------------------
// hrlf_checker - port-level checks for the request-line fingerprint
// Watches the result channel for slot ordering and framing.
// ----------------------------------------------------------------------------
module hrlf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // a stalled transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // slots of one fingerprint follow without gaps and in order
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1))
        else $error("slot sequence broken");

    // tlast marks slot 13 and nothing else; padding stays zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[3:0] == 4'd13) == m_tlast) && (m_tdata[23:20] == 4'd0))
        else $error("bad slot framing");

    // a fresh fingerprint starts at slot 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (m_tdata[3:0] == 4'd0) || !$past(m_tlast))
        else $error("fingerprint does not start at slot 0");

    // nothing is offered straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind http_request_line_fingerprint hrlf_checker u_hrlf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* tb/http_request_line_fingerprint_checker.sv */
// ----------------------------------------------------------------------------
// http_request_line_fingerprint_checker - request-line fingerprint scoreboard
// Watches both stream channels, recomputes the fourteen fingerprint slots
// from every accepted header byte and compares each slot transaction.
// ----------------------------------------------------------------------------
module http_request_line_fingerprint_checker
    import hrlf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_header
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [3:0] slot_index, [19:4] slot_value, [23:20] zero
    input  logic        m_tlast,   // final_slot
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        slot_t  slot;
        value_t value;
        logic   final_flag;
    } slot_result_t;

    slot_result_t expected_slots[$];

    // shadow of the classifier state
    logic [3:0]  cmd_code;
    logic        cmd_found;
    logic [3:0]  proto_code;
    logic        proto_found;
    logic [23:0] recent;
    logic        dot_wait;
    logic        slash_wait;
    logic        query_on;
    logic        line_done;
    count_t      length_count;
    count_t      char_count [NUM_CNT];

    function automatic count_t count_up(input count_t v);
        return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic value_t slot_clip(input count_t v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[VALUE_W-1:0];
    endfunction

    task automatic clear_line_state();
        cmd_code     = CMD_OTHER;
        cmd_found    = 1'b0;
        proto_code   = PROTO_OTHER;
        proto_found  = 1'b0;
        recent       = '0;
        dot_wait     = 1'b0;
        slash_wait   = 1'b0;
        query_on     = 1'b0;
        line_done    = 1'b0;
        length_count = '0;
        for (int k = 0; k < NUM_CNT; k++) char_count[k] = '0;
    endtask

    task automatic examine_byte(input logic [7:0] b);
        logic [7:0] p1, p2, p3;
        p1 = recent[7:0];
        p2 = recent[15:8];
        p3 = recent[23:16];

        if (!proto_found && (p2 == CH_ZERO || p2 == CH_ONE) && p1 == CH_DOT) begin
            if (b == CH_ZERO) begin
                proto_code = PROTO_X0; proto_found = 1'b1;
            end else if (b == CH_NINE) begin
                proto_code = PROTO_X9; proto_found = 1'b1;
            end else if (b == CH_ONE) begin
                proto_code = PROTO_X1; proto_found = 1'b1;
            end
        end

        if (!cmd_found) begin
            if (p2 == CH_G && p1 == CH_E && b == CH_T) begin
                cmd_code = CMD_GET; cmd_found = 1'b1;
            end else if (p3 == CH_H && p2 == CH_E && p1 == CH_A && b == CH_D) begin
                cmd_code = CMD_HEAD; cmd_found = 1'b1;
            end else if (p3 == CH_P && p2 == CH_O && p1 == CH_S && b == CH_T) begin
                cmd_code = CMD_POST; cmd_found = 1'b1;
            end
        end

        // pairs do not overlap: a completed pair clears its pending flag
        if (b == CH_DOT) begin
            if (dot_wait) begin
                char_count[CNT_DDOT] = count_up(char_count[CNT_DDOT]);
                dot_wait = 1'b0;
            end else begin
                dot_wait = 1'b1;
            end
        end else begin
            dot_wait = 1'b0;
        end
        if (b == CH_SLASH) begin
            if (slash_wait) begin
                char_count[CNT_DSLASH] = count_up(char_count[CNT_DSLASH]);
                slash_wait = 1'b0;
            end else begin
                slash_wait = 1'b1;
            end
        end else begin
            slash_wait = 1'b0;
        end

        case (b)
            CH_QUEST: query_on = 1'b1;
            CH_PCT:   char_count[CNT_PCT]  = count_up(char_count[CNT_PCT]);
            CH_AMP:   if (query_on) char_count[CNT_VAR] = count_up(char_count[CNT_VAR]);
            CH_APOS:  char_count[CNT_APOS] = count_up(char_count[CNT_APOS]);
            CH_PLUS:  char_count[CNT_PLUS] = count_up(char_count[CNT_PLUS]);
            CH_OPAR:  char_count[CNT_OPAR] = count_up(char_count[CNT_OPAR]);
            CH_CPAR:  char_count[CNT_CPAR] = count_up(char_count[CNT_CPAR]);
            CH_LT:    char_count[CNT_LT]   = count_up(char_count[CNT_LT]);
            CH_GT:    char_count[CNT_GT]   = count_up(char_count[CNT_GT]);
            CH_BSL:   char_count[CNT_BSL]  = count_up(char_count[CNT_BSL]);
            default: ;
        endcase

        recent = {recent[15:0], b};
    endtask

    task automatic take_byte(input logic [7:0] b, input logic eoh);
        slot_result_t r;
        length_count = count_up(length_count);
        if (!line_done) begin
            if (b == CH_LF) line_done = 1'b1;
            else examine_byte(b);
        end
        if (eoh) begin
            for (int k = 0; k <= LAST_SLOT; k++) begin
                r.slot       = slot_t'(k);
                r.final_flag = (r.slot == LAST_SLOT);
                if (r.slot == SLOT_CMD)        r.value = value_t'(cmd_code);
                else if (r.slot == SLOT_PROTO) r.value = value_t'(proto_code);
                else if (r.slot == SLOT_LEN)   r.value = slot_clip(length_count);
                else r.value = slot_clip(char_count[k - FIRST_CNT_SLOT]);
                expected_slots.push_back(r);
            end
            clear_line_state();
        end
    endtask

    task automatic report_mismatch(input string what, input slot_result_t want,
                                   input slot_result_t got);
        fail_count++;
        if (fail_count <= 10) begin
            $display({"[%0t] %s: expected slot %0d value %0d last %0b,",
                      " got slot %0d value %0d last %0b"},
                     $realtime, what, want.slot, want.value, want.final_flag,
                     got.slot, got.value, got.final_flag);
        end
    endtask

    always @(posedge aclk) begin : monitor
        slot_result_t got;
        slot_result_t want;
        if (!aresetn) begin
            clear_line_state();
            expected_slots.delete();
        end else begin
            if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.slot       = m_tdata[3:0];
                got.value      = m_tdata[19:4];
                got.final_flag = m_tlast;
                checked_count++;
                if (expected_slots.size() == 0) begin
                    report_mismatch("unexpected slot", '0, got);
                end else begin
                    want = expected_slots.pop_front();
                    if (got.slot != want.slot || got.value != want.value ||
                        got.final_flag != want.final_flag) begin
                        report_mismatch("slot mismatch", want, got);
                    end
                end
            end
        end
        pending_count = expected_slots.size();
    end

endmodule

/* tb/http_request_line_fingerprint_tb.sv */
// ----------------------------------------------------------------------------
// http_request_line_fingerprint_tb - stimulus and verdict for the fingerprint
// Feeds directed and random HTTP header bytes under varying back-pressure,
// including a long receiver hold-off, and reports the scoreboard's verdict.
// ----------------------------------------------------------------------------
module http_request_line_fingerprint_tb;
    import hrlf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
    logic        s_tlast  = 1'b0; // end_of_header
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [3:0] slot_index, [19:4] slot_value, [23:20] zero
    logic        m_tlast;         // final_slot

    int fail_count;
    int pending_count;
    int checked_count;

    // idling odds in percent for each side, changed per phase
    int send_idle_pct = 21;
    int recv_idle_pct = 51;

    // long receiver hold-off: the stimulus bumps the request, the receiver counts
    int stall_req  = 0;
    int stall_seen = 0;
    int stall_len  = 0;
    int hold_left  = 0;

    int bytes_sent   = 0;
    int headers_sent = 0;

    logic [7:0] hdr_bytes[$];

    // 12 ns period
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    http_request_line_fingerprint u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    http_request_line_fingerprint_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // Receiver: drive tready at the falling edge. A pending hold-off request
    // takes priority and keeps tready low for a counted stretch of cycles.
    always @(negedge aclk) begin
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            hold_left  = stall_len;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (recv_idle_pct == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one byte, idling at random first, and hold it until the transaction
    // completes. Entered and left at a falling edge, so tvalid stays high across
    // back-to-back bytes without being dropped in between.
    task automatic push_byte(input logic [7:0] b, input logic eoh);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoh;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Send the assembled header, marking its final byte, and empty the buffer.
    task automatic send_header();
        for (int i = 0; i < hdr_bytes.size(); i++) begin
            push_byte(hdr_bytes[i], i == hdr_bytes.size() - 1);
        end
        hdr_bytes.delete();
        headers_sent++;
    endtask

    function automatic void add_text(input string t);
        for (int i = 0; i < t.len(); i++) hdr_bytes.push_back(t[i]);
    endfunction

    // Bias the path towards the bytes the fingerprint counts.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(15))
            0:  return CH_DOT;
            1:  return CH_SLASH;
            2:  return CH_QUEST;
            3:  return CH_AMP;
            4:  return CH_PCT;
            5:  return CH_APOS;
            6:  return CH_PLUS;
            7:  return CH_BSL;
            8:  return CH_OPAR;
            9:  return CH_CPAR;
            10: return CH_LT;
            11: return CH_GT;
            12: return $urandom_range(1) ? CH_ZERO : CH_ONE;
            13: return CH_NINE;
            default: return 8'($urandom_range(97, 122));
        endcase
    endfunction

    function automatic void add_command();
        case ($urandom_range(4))
            0: add_text("GET");
            1: add_text("POST");
            2: add_text("HEAD");
            3: add_text("GE");  // near miss
            default: begin
                hdr_bytes.push_back(8'($urandom_range(65, 90)));
                hdr_bytes.push_back(8'($urandom_range(65, 90)));
                hdr_bytes.push_back(8'($urandom_range(65, 90)));
            end
        endcase
    endfunction

    function automatic void add_version();
        case ($urandom_range(2))
            0: hdr_bytes.push_back(CH_ZERO);
            1: hdr_bytes.push_back(CH_ONE);
            default: hdr_bytes.push_back(8'($urandom_range(50, 56)));
        endcase
        hdr_bytes.push_back(CH_DOT);
        case ($urandom_range(3))
            0: hdr_bytes.push_back(CH_ZERO);
            1: hdr_bytes.push_back(CH_ONE);
            2: hdr_bytes.push_back(CH_NINE);
            default: hdr_bytes.push_back(8'($urandom_range(50, 56)));
        endcase
    endfunction

    // Mostly well-formed request lines with random content; the rest is raw
    // noise or a line cut short at a random point.
    task automatic build_request_line();
        int n;
        if ($urandom_range(4) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) hdr_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        add_command();
        hdr_bytes.push_back(8'd32);
        n = $urandom_range(0, 10);
        repeat (n) begin
            if ($urandom_range(7) == 0) add_command();  // second command: first one wins
            else hdr_bytes.push_back(pick_char());
        end
        add_text(" HTTP/");
        add_version();
        if ($urandom_range(3) == 0) begin
            hdr_bytes.push_back(8'd32);
            add_version();  // a later version must not override the first
        end
        if ($urandom_range(1)) begin
            hdr_bytes.push_back(CH_LF);
            n = $urandom_range(0, 4);
            repeat (n) hdr_bytes.push_back(pick_char());
        end
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, hdr_bytes.size());
            while (hdr_bytes.size() > n) void'(hdr_bytes.pop_back());
        end
    endtask

    initial begin
        int goal;

        // hold reset low, then release it at a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed headers, phase one idling.
        // Newline mid-header with a trailing all-ones byte after it.
        add_text("GET");
        hdr_bytes.push_back(CH_LF);
        hdr_bytes.push_back(8'hFF);
        send_header();
        // HEAD, 0.9 protocol, then four dots: two non-overlapping pairs.
        add_text("HEAD0.9....");
        send_header();
        // POST, ampersand before and after the query mark, a double slash,
        // and the newline as the final byte.
        add_text("POST&?&//");
        hdr_bytes.push_back(CH_LF);
        send_header();
        // Single zero byte: nothing matches.
        hdr_bytes.push_back(8'h00);
        send_header();

        // Pressure: hold the receiver off for a long stretch and offer ten short
        // headers, enough for the block to stall its input.
        stall_len = 250;
        stall_req++;
        repeat (10) begin
            repeat ($urandom_range(1, 3)) hdr_bytes.push_back(pick_char());
            send_header();
        end
        // drop tvalid and pause the sender until every slot has drained
        s_tvalid <= 1'b0;
        wait (pending_count == 0);
        @(negedge aclk);

        // Random request lines across the three idling phases.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 21; recv_idle_pct = 51; end
                1: begin send_idle_pct = 51; recv_idle_pct = 21; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            goal = bytes_sent + 65;
            while (bytes_sent < goal) begin
                build_request_line();
                send_header();
            end
        end

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // drain, then allow for any stray late transaction
        wait (pending_count == 0);
        repeat (40) @(posedge aclk);

        $display("Sent %0d header bytes in %0d headers; %0d slot transactions checked.",
                 bytes_sent, headers_sent, checked_count);
        $display("Covered command and protocol matching, pair counting and long hold-off.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures, %0d slots never arrived", fail_count, pending_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog well beyond the slowest correct run
    initial begin
        #6_000_000;
        $display("Timed out with %0d slots outstanding", pending_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
